// ===== rtl/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg
// shared types, kind codes and saturation helpers for the constraint residual
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIST_W  = 31;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned ACC_W   = 66;
  localparam int unsigned ROOT_W  = 33;
  localparam int unsigned NUM_G   = 8;

  localparam logic [2:0] KIND_DISTANCE      = 3'd0;
  localparam logic [2:0] KIND_HORIZONTAL    = 3'd1;
  localparam logic [2:0] KIND_VERTICAL      = 3'd2;
  localparam logic [2:0] KIND_PARALLEL      = 3'd3;
  localparam logic [2:0] KIND_PERPENDICULAR = 3'd4;
  localparam logic [2:0] KIND_COINCIDENT    = 3'd5;

  typedef struct packed {
    logic [2:0]                 kind;
    logic signed [COORD_W-1:0]  a_x;
    logic signed [COORD_W-1:0]  a_y;
    logic signed [COORD_W-1:0]  b_x;
    logic signed [COORD_W-1:0]  b_y;
    logic signed [COORD_W-1:0]  c_x;
    logic signed [COORD_W-1:0]  c_y;
    logic signed [COORD_W-1:0]  d_x;
    logic signed [COORD_W-1:0]  d_y;
    logic [DIST_W-1:0]          target_distance;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  residual;
    logic signed [COORD_W-1:0]  grad_0;
    logic signed [COORD_W-1:0]  grad_1;
    logic signed [COORD_W-1:0]  grad_2;
    logic signed [COORD_W-1:0]  grad_3;
    logic signed [COORD_W-1:0]  grad_4;
    logic signed [COORD_W-1:0]  grad_5;
    logic signed [COORD_W-1:0]  grad_6;
    logic signed [COORD_W-1:0]  grad_7;
    logic                       satisfied;
  } out_word_t;

  // clamp a wide signed value to the signed 32 bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -ACC_W'(64'sh8000_0000);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

  // magnitude of a coordinate difference, always below 2^32
  function automatic logic [COORD_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] m;
    m = v[DIFF_W-1] ? -v : v;
    mag33 = m[COORD_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] ext66(input logic signed [DIFF_W-1:0] v);
    ext66 = {{(ACC_W-DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/geometric_constraint_residual.sv =====
// ----------------------------------------------------------------------------
// geometric_constraint_residual
// residual, jacobian row and satisfied flag for one 2d constraint per word
// ----------------------------------------------------------------------------
// One constraint word enters per clock and one result word leaves per clock,
// in order, while the result side keeps taking words. The depth comes from
// the square root, which retires one radicand bit pair per stage over 33
// stages, and the gradient divider, which retires one quotient bit per stage.
// All stages move together: when the result word is not taken, the whole pipe
// holds and item_ready drops. The tolerance register may be written at any
// time the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module geometric_constraint_residual import gcr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  in_word_t            item,
  output logic                result_valid,
  input  logic                result_ready,
  output out_word_t           result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [DIST_W-1:0]   cfg_tolerance
);

  localparam int unsigned QBITS   = FRAC_BITS + 1;
  localparam int unsigned SQ_LAT  = ACC_W / 2;
  localparam int unsigned NS      = SQ_LAT + QBITS;
  localparam logic signed [COORD_W-1:0] ONE = COORD_W'(64'sd1 <<< FRAC_BITS);

  // payload carried alongside the root and divider
  typedef struct packed {
    logic [2:0]                       kind;
    logic [DIST_W-1:0]                target;
    logic                             sx;
    logic                             sy;
    logic [COORD_W-1:0]               mx;
    logic [COORD_W-1:0]               my;
    logic signed [COORD_W-1:0]        res;
    logic [NUM_G-1:0][COORD_W-1:0]    g;
  } side_t;

  logic adv;
  logic [DIST_W-1:0] tolerance;

  // flow control: everything advances when the output slot is free or taken
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= DIST_W'(7);
    end else if (cfg_valid) begin
      tolerance <= cfg_tolerance;
    end
  end

  // stage 1: input register
  logic     v1;
  in_word_t w1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      w1 <= item;
    end
  end

  // stage 2: segment differences, exact in 33 bits
  logic v2;
  logic [2:0] kind2;
  logic [DIST_W-1:0] tgt2;
  logic signed [DIFF_W-1:0] dx1_2, dy1_2, dx2_2, dy2_2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kind2 <= w1.kind;
      tgt2  <= w1.target_distance;
      dx1_2 <= DIFF_W'(w1.b_x) - DIFF_W'(w1.a_x);
      dy1_2 <= DIFF_W'(w1.b_y) - DIFF_W'(w1.a_y);
      dx2_2 <= DIFF_W'(w1.d_x) - DIFF_W'(w1.c_x);
      dy2_2 <= DIFF_W'(w1.d_y) - DIFF_W'(w1.c_y);
    end
  end

  // stage 3: pick multiplier operands by kind, split into sign and magnitude
  logic signed [DIFF_W-1:0] opa0, opb0, opa1, opb1;
  logic neg1;
  always_comb begin
    opa0 = dx1_2;
    opa1 = dy1_2;
    priority if (kind2 == KIND_DISTANCE || kind2 == KIND_COINCIDENT) begin
      opb0 = dx1_2;
      opb1 = dy1_2;
      neg1 = 1'b0;
    end else if (kind2 == KIND_PARALLEL) begin
      opb0 = dy2_2;
      opb1 = dx2_2;
      neg1 = 1'b1;
    end else begin
      opb0 = dx2_2;
      opb1 = dy2_2;
      neg1 = 1'b0;
    end
  end

  logic v3;
  logic [2:0] kind3;
  logic [DIST_W-1:0] tgt3;
  logic signed [DIFF_W-1:0] dx1_3, dy1_3, dx2_3, dy2_3;
  logic [COORD_W-1:0] ma0, mb0, ma1, mb1;
  logic s0_3, s1_3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kind3 <= kind2;
      tgt3  <= tgt2;
      dx1_3 <= dx1_2;
      dy1_3 <= dy1_2;
      dx2_3 <= dx2_2;
      dy2_3 <= dy2_2;
      ma0   <= mag33(opa0);
      mb0   <= mag33(opb0);
      ma1   <= mag33(opa1);
      mb1   <= mag33(opb1);
      s0_3  <= opa0[DIFF_W-1] ^ opb0[DIFF_W-1];
      s1_3  <= opa1[DIFF_W-1] ^ opb1[DIFF_W-1] ^ neg1;
    end
  end

  // stage 4: two unsigned 32x32 products
  logic v4;
  logic [2:0] kind4;
  logic [DIST_W-1:0] tgt4;
  logic signed [DIFF_W-1:0] dx1_4, dy1_4, dx2_4, dy2_4;
  logic [2*COORD_W-1:0] p0, p1;
  logic s0_4, s1_4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kind4 <= kind3;
      tgt4  <= tgt3;
      dx1_4 <= dx1_3;
      dy1_4 <= dy1_3;
      dx2_4 <= dx2_3;
      dy2_4 <= dy2_3;
      p0    <= ma0 * mb0;
      p1    <= ma1 * mb1;
      s0_4  <= s0_3;
      s1_4  <= s1_3;
    end
  end

  // stage 5: exact signed sum of products (sum of squares for point kinds)
  logic signed [ACC_W-1:0] t0, t1;
  assign t0 = s0_4 ? -$signed({2'b00, p0}) : $signed({2'b00, p0});
  assign t1 = s1_4 ? -$signed({2'b00, p1}) : $signed({2'b00, p1});

  logic v5;
  logic [2:0] kind5;
  logic [DIST_W-1:0] tgt5;
  logic signed [DIFF_W-1:0] dx1_5, dy1_5, dx2_5, dy2_5;
  logic signed [ACC_W-1:0] acc;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kind5 <= kind4;
      tgt5  <= tgt4;
      dx1_5 <= dx1_4;
      dy1_5 <= dy1_4;
      dx2_5 <= dx2_4;
      dy2_5 <= dy2_4;
      acc   <= t0 + t1;
    end
  end

  // line kinds (horizontal, vertical, parallel, perpendicular) are settled here and ride along the root pipe
  side_t side_in;
  logic signed [ACC_W-1:0] acc_sh;
  assign acc_sh = acc >>> FRAC_BITS;

  always_comb begin
    side_in.kind   = kind5;
    side_in.target = tgt5;
    side_in.sx     = dx1_5[DIFF_W-1];
    side_in.sy     = dy1_5[DIFF_W-1];
    side_in.mx     = mag33(dx1_5);
    side_in.my     = mag33(dy1_5);
    side_in.res    = '0;
    side_in.g      = '0;
    unique case (kind5)
      KIND_HORIZONTAL: begin
        side_in.res  = sat32(ext66(dy1_5));
        side_in.g[0] = -ONE;
        side_in.g[1] = ONE;
      end
      KIND_VERTICAL: begin
        side_in.res  = sat32(ext66(dx1_5));
        side_in.g[0] = -ONE;
        side_in.g[1] = ONE;
      end
      KIND_PARALLEL: begin
        side_in.res  = sat32(acc_sh);
        side_in.g[0] = sat32(-ext66(dy2_5));
        side_in.g[1] = sat32(ext66(dx2_5));
        side_in.g[2] = sat32(ext66(dy2_5));
        side_in.g[3] = sat32(-ext66(dx2_5));
        side_in.g[4] = sat32(ext66(dy1_5));
        side_in.g[5] = sat32(-ext66(dx1_5));
        side_in.g[6] = sat32(-ext66(dy1_5));
        side_in.g[7] = sat32(ext66(dx1_5));
      end
      KIND_PERPENDICULAR: begin
        side_in.res  = sat32(acc_sh);
        side_in.g[0] = sat32(-ext66(dx2_5));
        side_in.g[1] = sat32(-ext66(dy2_5));
        side_in.g[2] = sat32(ext66(dx2_5));
        side_in.g[3] = sat32(ext66(dy2_5));
        side_in.g[4] = sat32(-ext66(dx1_5));
        side_in.g[5] = sat32(-ext66(dy1_5));
        side_in.g[6] = sat32(ext66(dx1_5));
        side_in.g[7] = sat32(ext66(dy1_5));
      end
      default: begin
        // point kinds finish after the divider, unknown kinds stay zero
      end
    endcase
  end

  // square root of the sum of squares, 33 stages
  logic [ROOT_W-1:0] root;
  gcr_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (acc),
    .root (root)
  );

  // side pipe: entry k lines up with root stage k, then divider stages
  side_t side_q [NS];
  logic  vs     [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        vs[k] <= 1'b0;
      end
    end else if (adv) begin
      vs[0] <= v5;
      for (int k = 1; k < NS; k++) begin
        vs[k] <= vs[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // unit gradient components |d| * 2^FRAC_BITS / span, both in parallel
  logic [QBITS-1:0]  qx, qy;
  logic [ROOT_W-1:0] span, span_y;

  gcr_div #(.QBITS(QBITS)) u_div_x (
    .clk     (clk),
    .en      (adv),
    .num     (side_q[SQ_LAT-1].mx),
    .den     (root),
    .quo     (qx),
    .den_out (span)
  );

  gcr_div #(.QBITS(QBITS)) u_div_y (
    .clk     (clk),
    .en      (adv),
    .num     (side_q[SQ_LAT-1].my),
    .den     (root),
    .quo     (qy),
    .den_out (span_y)
  );

  // final stage: point-kind residual and gradients, satisfied flag
  side_t sl;
  out_word_t res_next;
  logic signed [COORD_W-1:0] gx, gy, r;
  logic [COORD_W-1:0] r_mag;
  logic span_zero;

  assign sl        = side_q[NS-1];
  assign span_zero = (span == '0) || (span_y == '0);

  always_comb begin
    gx = $signed(COORD_W'(qx));
    gy = $signed(COORD_W'(qy));
    if (sl.sx) begin
      gx = -gx;
    end
    if (sl.sy) begin
      gy = -gy;
    end
    r = sl.res;
    res_next.grad_0 = sl.g[0];
    res_next.grad_1 = sl.g[1];
    res_next.grad_2 = sl.g[2];
    res_next.grad_3 = sl.g[3];
    res_next.grad_4 = sl.g[4];
    res_next.grad_5 = sl.g[5];
    res_next.grad_6 = sl.g[6];
    res_next.grad_7 = sl.g[7];
    if (sl.kind == KIND_DISTANCE || sl.kind == KIND_COINCIDENT) begin
      if (sl.kind == KIND_DISTANCE) begin
        r = sat32(ACC_W'(span) - ACC_W'(sl.target));
      end else begin
        r = sat32(ACC_W'(span));
      end
      if (span_zero) begin
        res_next.grad_0 = '0;
        res_next.grad_1 = '0;
        res_next.grad_2 = '0;
        res_next.grad_3 = '0;
      end else begin
        res_next.grad_0 = -gx;
        res_next.grad_1 = -gy;
        res_next.grad_2 = gx;
        res_next.grad_3 = gy;
      end
    end
    r_mag = r[COORD_W-1] ? COORD_W'(-r) : COORD_W'(r);
    res_next.residual  = r;
    res_next.satisfied = r_mag <= {1'b0, tolerance};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vs[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

// ===== rtl/gcr_isqrt.sv =====
// ----------------------------------------------------------------------------
// gcr_isqrt
// pipelined integer square root, one radicand bit pair per stage
// ----------------------------------------------------------------------------
module gcr_isqrt import gcr_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ACC_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  localparam int unsigned STEPS = ACC_W / 2;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned WRK_W = REM_W + 2;

  logic [ACC_W-1:0]  rad_q  [STEPS-1];
  logic [REM_W-1:0]  rem_q  [STEPS];
  logic [ROOT_W-1:0] root_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [ACC_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [WRK_W-1:0]  work;
    logic [WRK_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next pair and try root*4+1
    assign work  = {rem_in, rad_in[ACC_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = work >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? REM_W'(work - trial) : REM_W'(work);
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
      end
    end

    if (k < STEPS - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[k] <= {rad_in[ACC_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[STEPS-1];

endmodule

// ===== rtl/gcr_div.sv =====
// ----------------------------------------------------------------------------
// gcr_div
// pipelined restoring divider for a dividend no larger than the divisor,
// one quotient bit per stage, the divisor travels along
// ----------------------------------------------------------------------------
module gcr_div import gcr_pkg::*; #(
  parameter int unsigned QBITS = 17
) (
  input  logic              clk,
  input  logic              en,
  input  logic [COORD_W-1:0] num,
  input  logic [ROOT_W-1:0] den,
  output logic [QBITS-1:0]  quo,
  output logic [ROOT_W-1:0] den_out
);

  localparam int unsigned WRK_W = ROOT_W + 1;

  logic [ROOT_W-1:0] rem_q [QBITS-1];
  logic [ROOT_W-1:0] den_q [QBITS];
  logic [QBITS-1:0]  quo_q [QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_step
    logic [WRK_W-1:0]  work;
    logic [ROOT_W-1:0] den_in;
    logic [QBITS-1:0]  quo_in;
    logic              ge;

    if (j == 0) begin : g_first
      assign work   = {2'b00, num};
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign work   = {rem_q[j-1], 1'b0};
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign ge = work >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j] <= den_in;
        quo_q[j] <= {quo_in[QBITS-2:0], ge};
      end
    end

    if (j < QBITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j] <= ge ? ROOT_W'(work - {1'b0, den_in}) : ROOT_W'(work);
        end
      end
    end
  end

  assign quo     = quo_q[QBITS-1];
  assign den_out = den_q[QBITS-1];

endmodule
